>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk, off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge (may itself be an implication).
`define FSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define FSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/fsg_pkg.sv
// ---------------------------------------------------------------------------
// fsg_pkg
// Shared constants, codes and types of the fire spread grid stencil.
// ---------------------------------------------------------------------------
package fsg_pkg;

	// Largest supported grid edge.
	localparam int MAX_WIDTH = 32;
	// Row / column counter width.
	localparam int CNT_W     = $clog2(MAX_WIDTH);
	// Grid width register and effective width.
	localparam int WID_W     = 6;
	// Cell code width.
	localparam int CELL_W    = 3;
	// Configuration port.
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 6;
	// Front to back queue.
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	// Cell codes.
	localparam logic [CELL_W-1:0] ST_UNTOUCHED = 3'd0;
	localparam logic [CELL_W-1:0] ST_BURNING   = 3'd1;
	localparam logic [CELL_W-1:0] ST_BURNING2  = 3'd2;
	localparam logic [CELL_W-1:0] ST_BURNT     = 3'd3;
	localparam logic [CELL_W-1:0] ST_ROCK      = 3'd4;

	// Neighborhood modes.
	localparam logic MODE_MOORE = 1'b0;
	localparam logic MODE_STAR  = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NBR_MODE   = 4'd1;

	// One classified item on its way to the back end.
	typedef struct packed {
		logic [CELL_W-1:0] code;
		logic              first;
		logic              last;
	} cell_item_t;

	// Live configuration seen by the back end.
	typedef struct packed {
		logic [WID_W-1:0] width;
		logic             mode;
	} cfg_t;

endpackage

>>> hdl/fire_spread_grid_stencil.sv
// ---------------------------------------------------------------------------
// fire_spread_grid_stencil
// Forest fire automaton over a raster stream of grid cells: next-generation
// state of each cell from a 3x3 window held in two row delay lines.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_index (0 width, 1 mode), cfg_data
//  in       | in_valid/in_ready    | cell_state
//  out      | out_valid/out_ready  | next_state, frame_last
//
//  One item per cycle in and out when not stalled; a cell's result is loaded
//  when the cell W+1 places later leaves the queue, and shows on out the cycle after.
//  Frame end: W+1 padding steps (one result each, no pop) drain the window;
//  at full rate the 4-entry queue takes three more items, then input stalls.
//  Reset (arst_n low) gives width 32, Moore mode, frame start.
//  A stalled output holds the back end; the 4-entry queue absorbs it first.
// ---------------------------------------------------------------------------
module fire_spread_grid_stencil (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsg_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fsg_pkg::CELL_W-1:0]    cell_state,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fsg_pkg::CELL_W-1:0]    next_state,
	output logic                          frame_last
);

	// front -> queue
	logic                q_ready;
	logic                q_push;
	fsg_pkg::cell_item_t q_in_item;
	// queue -> back
	logic                q_valid;
	logic                q_pop;
	fsg_pkg::cell_item_t q_out_item;
	// live config (width already clamped)
	fsg_pkg::cfg_t       cfg;

	// counters and frame tags
	fsg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_state (cell_state),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_item     (q_in_item),
		.cfg        (cfg)
	);

	// decouples input from flush and output stalls
	fsg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in_item),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_item   (q_out_item)
	);

	// window, rule, flush, output register
	fsg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (q_valid),
		.q_item     (q_out_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_state (next_state),
		.frame_last (frame_last)
	);

endmodule

>>> hdl/fsg_front.sv
// ---------------------------------------------------------------------------
// fsg_front
// Config registers, raster position counters and frame tagging of items.
// ---------------------------------------------------------------------------
module fsg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsg_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fsg_pkg::CELL_W-1:0]     cell_state,
	input  logic                           q_ready,
	output logic                           q_push,
	output fsg_pkg::cell_item_t            q_item,
	output fsg_pkg::cfg_t                  cfg
);

	logic [fsg_pkg::WID_W-1:0] grid_width_q;
	logic                      mode_q;
	logic [fsg_pkg::CNT_W-1:0] col_q;
	logic [fsg_pkg::CNT_W-1:0] row_q;
	logic [fsg_pkg::WID_W-1:0] eff_w;
	logic                      is_first;
	logic                      is_last;
	logic                      col_end;

	assign cfg_ready = 1'b1;

	// clamp width into 2..MAX_WIDTH
	always_comb begin
		if (grid_width_q < fsg_pkg::WID_W'(2)) begin
			eff_w = fsg_pkg::WID_W'(2);
		end else if (grid_width_q > fsg_pkg::WID_W'(fsg_pkg::MAX_WIDTH)) begin
			eff_w = fsg_pkg::WID_W'(fsg_pkg::MAX_WIDTH);
		end else begin
			eff_w = grid_width_q;
		end
	end

	assign col_end  = (fsg_pkg::WID_W'(col_q) == eff_w - fsg_pkg::WID_W'(1));
	assign is_first = (col_q == '0) && (row_q == '0);
	assign is_last  = col_end && (fsg_pkg::WID_W'(row_q) == eff_w - fsg_pkg::WID_W'(1));

	assign in_ready     = q_ready;
	assign q_push       = in_valid && q_ready;
	assign q_item.code  = cell_state;
	assign q_item.first = is_first;
	assign q_item.last  = is_last;

	assign cfg.width = eff_w;
	assign cfg.mode  = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= fsg_pkg::WID_W'(32);
			mode_q       <= fsg_pkg::MODE_MOORE;
			col_q        <= '0;
			row_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fsg_pkg::REG_GRID_WIDTH: begin
					grid_width_q <= cfg_data;
					col_q        <= '0;
					row_q        <= '0;
				end
				fsg_pkg::REG_NBR_MODE: begin
					mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (q_push) begin
			if (is_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + fsg_pkg::CNT_W'(1);
			end else begin
				col_q <= col_q + fsg_pkg::CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/fsg_queue.sv
// ---------------------------------------------------------------------------
// fsg_queue
// Small flop FIFO between front and back end.
// ---------------------------------------------------------------------------
module fsg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fsg_pkg::cell_item_t push_item,
	output logic                push_ready,
	input  logic                pop,
	output logic                pop_valid,
	output fsg_pkg::cell_item_t pop_item
);

	fsg_pkg::cell_item_t         mem_q [fsg_pkg::Q_DEPTH];
	logic [fsg_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [fsg_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [fsg_pkg::Q_CNT_W-1:0] count_q;

	assign push_ready = (count_q != fsg_pkg::Q_CNT_W'(fsg_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + fsg_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fsg_pkg::Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + fsg_pkg::Q_CNT_W'(1);
				2'b01:   count_q <= count_q - fsg_pkg::Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/fsg_back.sv
// ---------------------------------------------------------------------------
// fsg_back
// Row delay lines, 3x3 window, next-state rule, end-of-frame flush and
// output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsg_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fsg_pkg::cfg_t              cfg,
	input  logic                       q_valid,
	input  fsg_pkg::cell_item_t        q_item,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fsg_pkg::CELL_W-1:0] next_state,
	output logic                       frame_last
);

	// window: t = two rows up, m = one row up (center row), b = newest row
	logic [fsg_pkg::CELL_W-1:0] line1_q [fsg_pkg::MAX_WIDTH];
	logic                       line2_q [fsg_pkg::MAX_WIDTH];
	logic [fsg_pkg::CELL_W-1:0] m1_q;
	logic                       m2_q;
	logic                       t1_q;
	logic                       t2_q;
	logic                       b1_q;
	logic                       b2_q;

	logic [fsg_pkg::WID_W-1:0]  fill_q;
	logic [fsg_pkg::CNT_W-1:0]  cc_q;
	logic [fsg_pkg::CNT_W-1:0]  cr_q;
	logic                       flush_q;
	logic [fsg_pkg::WID_W-1:0]  pad_q;

	logic                       out_valid_q;
	logic [fsg_pkg::CELL_W-1:0] next_q;
	logic                       last_q;

	logic [fsg_pkg::CELL_W-1:0] x_cell;
	logic                       x_burn;
	logic [fsg_pkg::CELL_W-1:0] m0;
	logic                       t0;
	logic                       first;
	logic                       emit;
	logic                       step;
	logic [fsg_pkg::WID_W-1:0]  w_m1;
	logic                       up_ok, dn_ok, lf_ok, rt_ok;
	logic                       hot;
	logic [fsg_pkg::CELL_W-1:0] nxt;

	// padding cells during flush never burn
	assign x_cell = flush_q ? fsg_pkg::ST_UNTOUCHED : q_item.code;
	assign x_burn = (x_cell == fsg_pkg::ST_BURNING);
	assign m0     = line1_q[0];
	assign t0     = line2_q[0];
	assign w_m1   = cfg.width - fsg_pkg::WID_W'(1);

	// fill_q saturates at W+1: results start once W+1 cells are in
	assign first = !flush_q && q_item.first;
	assign emit  = flush_q || (!first && (fill_q == cfg.width + fsg_pkg::WID_W'(1)));
	assign step  = (flush_q || q_valid) && (!emit || !out_valid_q || out_ready);
	assign q_pop = step && !flush_q;

	// grid edges of the center cell
	assign up_ok = (cr_q != '0);
	assign dn_ok = (fsg_pkg::WID_W'(cr_q) != w_m1);
	assign lf_ok = (cc_q != '0);
	assign rt_ok = (fsg_pkg::WID_W'(cc_q) != w_m1);

	always_comb begin
		hot = (t1_q && up_ok) || (b1_q && dn_ok) || (m2_q && lf_ok) ||
		      ((m0 == fsg_pkg::ST_BURNING) && rt_ok);
		if (cfg.mode == fsg_pkg::MODE_MOORE) begin
			hot = hot || (t2_q && up_ok && lf_ok) || (t0 && up_ok && rt_ok) ||
			      (b2_q && dn_ok && lf_ok) || (x_burn && dn_ok && rt_ok);
		end
	end

	always_comb begin
		unique case (m1_q) inside
			fsg_pkg::ST_BURNING:                   nxt = fsg_pkg::ST_BURNING2;
			fsg_pkg::ST_BURNING2, fsg_pkg::ST_BURNT: nxt = fsg_pkg::ST_BURNT;
			fsg_pkg::ST_ROCK:                      nxt = fsg_pkg::ST_ROCK;
			default: nxt = hot ? fsg_pkg::ST_BURNING : fsg_pkg::ST_UNTOUCHED;
		endcase
	end

	// variable-length row delay: new cell enters at stage W-1
	for (genvar j = 0; j < fsg_pkg::MAX_WIDTH; j++) begin : g_line
		if (j == fsg_pkg::MAX_WIDTH - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (step) begin
					line1_q[j] <= x_cell;
					line2_q[j] <= (m0 == fsg_pkg::ST_BURNING);
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (step) begin
					if (fsg_pkg::WID_W'(j + 1) == cfg.width) begin
						line1_q[j] <= x_cell;
						line2_q[j] <= (m0 == fsg_pkg::ST_BURNING);
					end else begin
						line1_q[j] <= line1_q[j+1];
						line2_q[j] <= line2_q[j+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			b1_q <= x_burn;
			b2_q <= b1_q;
			m1_q <= m0;
			m2_q <= (m1_q == fsg_pkg::ST_BURNING);
			t1_q <= t0;
			t2_q <= t1_q;
		end
		if (step && emit) begin
			next_q <= nxt;
			last_q <= flush_q && (pad_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			cc_q        <= '0;
			cr_q        <= '0;
			flush_q     <= 1'b0;
			pad_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				if (first) begin
					fill_q <= fsg_pkg::WID_W'(1);
					cc_q   <= '0;
					cr_q   <= '0;
				end else begin
					if (fill_q != cfg.width + fsg_pkg::WID_W'(1)) begin
						fill_q <= fill_q + fsg_pkg::WID_W'(1);
					end
					if (emit) begin
						if (fsg_pkg::WID_W'(cc_q) == w_m1) begin
							cc_q <= '0;
							cr_q <= cr_q + fsg_pkg::CNT_W'(1);
						end else begin
							cc_q <= cc_q + fsg_pkg::CNT_W'(1);
						end
					end
				end
				// final cell: run W+1 padding steps to drain the window
				if (flush_q) begin
					if (pad_q == '0) begin
						flush_q <= 1'b0;
					end else begin
						pad_q <= pad_q - fsg_pkg::WID_W'(1);
					end
				end else if (q_item.last) begin
					flush_q <= 1'b1;
					pad_q   <= cfg.width;
				end
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign next_state = next_q;
	assign frame_last = last_q;

	`FSG_ASSERT(a_center_in_grid, (step && emit) |-> ((fsg_pkg::WID_W'(cc_q) < cfg.width) && (fsg_pkg::WID_W'(cr_q) < cfg.width)), "result center outside grid")
	`FSG_ASSERT(a_no_pop_in_flush, !(flush_q && q_pop), "queue popped during flush")
	`FSG_ASSERT_NEXT(a_flush_ends, step && flush_q && (pad_q == '0), !flush_q, "flush did not end after last padding step")

endmodule

>>> sim/fire_spread_grid_stencil_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fire_spread_grid_stencil_check
// Watches the cfg, in and out channels of the stencil, keeps its own window
// of recent cells and frame position, and compares every result with the
// oldest predicted next-generation state.
// ---------------------------------------------------------------------------
module fire_spread_grid_stencil_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [fsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsg_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [fsg_pkg::CELL_W-1:0]    cell_state,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [fsg_pkg::CELL_W-1:0]    next_state,
	input  logic                          frame_last,
	output int                            fail_count,
	output int                            pending
);

	localparam int HIST_D = 2 * fsg_pkg::MAX_WIDTH + 3;

	typedef struct packed {
		logic [fsg_pkg::CELL_W-1:0] state;
		logic                       last;
	} cell_result_t;

	logic [fsg_pkg::CELL_W-1:0] window [HIST_D];   // window[0] is the newest cell
	int                         col_pos;
	int                         row_pos;
	logic [fsg_pkg::WID_W-1:0]  width_reg;
	logic                       mode_reg;
	cell_result_t               next_states [$];
	int                         errors;

	int                         eff_w;
	int                         col;
	int                         row;
	int                         k_lin;
	bit                         last_cell;
	cell_result_t               want;

	// Burning test at grid position (r, c); k is the linear index of the newest cell.
	function automatic bit burning_at(int r, int c, int w, int k);
		int idx;
		if (r < 0 || r >= w || c < 0 || c >= w)
			return 1'b0;
		idx = r * w + c;
		if (idx > k || k - idx >= HIST_D)
			return 1'b0;
		return window[k - idx] == fsg_pkg::ST_BURNING;
	endfunction

	function automatic logic [fsg_pkg::CELL_W-1:0] next_generation(int pos, int w, int k);
		int                         back;
		int                         r;
		int                         c;
		logic [fsg_pkg::CELL_W-1:0] cur;
		bit                         hot;
		back = k - pos;
		cur  = (back >= 0 && back < HIST_D) ? window[back] : fsg_pkg::ST_UNTOUCHED;
		r    = pos / w;
		c    = pos % w;
		case (cur) inside
			fsg_pkg::ST_BURNING:                     return fsg_pkg::ST_BURNING2;
			fsg_pkg::ST_BURNING2, fsg_pkg::ST_BURNT: return fsg_pkg::ST_BURNT;
			fsg_pkg::ST_ROCK:                        return fsg_pkg::ST_ROCK;
			default: begin
				hot = burning_at(r - 1, c, w, k) || burning_at(r + 1, c, w, k) ||
				      burning_at(r, c - 1, w, k) || burning_at(r, c + 1, w, k);
				if (mode_reg == fsg_pkg::MODE_MOORE)
					hot = hot || burning_at(r - 1, c - 1, w, k) ||
					      burning_at(r - 1, c + 1, w, k) ||
					      burning_at(r + 1, c - 1, w, k) ||
					      burning_at(r + 1, c + 1, w, k);
				return hot ? fsg_pkg::ST_BURNING : fsg_pkg::ST_UNTOUCHED;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_D; i++)
				window[i] = fsg_pkg::ST_UNTOUCHED;
			col_pos   = 0;
			row_pos   = 0;
			width_reg = fsg_pkg::WID_W'(fsg_pkg::MAX_WIDTH);
			mode_reg  = fsg_pkg::MODE_MOORE;
			next_states.delete();
			errors    = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// results first: a result never belongs to a cell taken at the same edge
			if (out_valid && out_ready) begin
				if (next_states.size() == 0) begin
					$display("%0t: unexpected result, expected none, got next_state %0d frame_last %0d",
						$time, next_state, frame_last);
					errors++;
				end else begin
					want = next_states.pop_front();
					if (next_state !== want.state) begin
						$display("%0t: next_state expected %0d, got %0d",
							$time, want.state, next_state);
						errors++;
					end
					if (frame_last !== want.last) begin
						$display("%0t: frame_last expected %0d, got %0d",
							$time, want.last, frame_last);
						errors++;
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fsg_pkg::REG_GRID_WIDTH) begin
					width_reg = cfg_data[fsg_pkg::WID_W-1:0];
					col_pos   = 0;
					row_pos   = 0;
				end else if (cfg_index == fsg_pkg::REG_NBR_MODE) begin
					mode_reg = cfg_data[0];
				end
			end

			if (in_valid && in_ready) begin
				eff_w = width_reg;
				if (eff_w < 2)
					eff_w = 2;
				if (eff_w > fsg_pkg::MAX_WIDTH)
					eff_w = fsg_pkg::MAX_WIDTH;
				col       = (col_pos >= eff_w) ? eff_w - 1 : col_pos;
				row       = (row_pos >= eff_w) ? eff_w - 1 : row_pos;
				k_lin     = row * eff_w + col;
				last_cell = (k_lin == eff_w * eff_w - 1);

				for (int i = HIST_D - 1; i > 0; i--)
					window[i] = window[i-1];
				window[0] = cell_state;

				// one row plus one cell of lag
				if (k_lin >= eff_w + 1) begin
					want.state = next_generation(k_lin - eff_w - 1, eff_w, k_lin);
					want.last  = 1'b0;
					next_states.push_back(want);
				end
				if (last_cell) begin
					// flush the last row and the cell before it
					for (int d = eff_w; d >= 0; d--) begin
						want.state = next_generation(k_lin - d, eff_w, k_lin);
						want.last  = (d == 0);
						next_states.push_back(want);
					end
					col_pos = 0;
					row_pos = 0;
				end else begin
					col++;
					if (col >= eff_w) begin
						col = 0;
						row++;
					end
					col_pos = col;
					row_pos = row;
				end
			end

			fail_count <= errors;
			pending    <= next_states.size();
		end
	end

endmodule

>>> sim/fire_spread_grid_stencil_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fire_spread_grid_stencil_tb
// Drives raster frames of cells into the fire spread stencil under random
// idle gaps on both sides, reconfigures width and neighborhood between
// phases, and takes the verdict from the checker beside the block.
// ---------------------------------------------------------------------------
module fire_spread_grid_stencil_tb;

	// Undefined cell codes; the block treats them as untouched.
	localparam logic [fsg_pkg::CELL_W-1:0] ST_SPARE5 = 3'd5;
	localparam logic [fsg_pkg::CELL_W-1:0] ST_SPARE6 = 3'd6;
	localparam logic [fsg_pkg::CELL_W-1:0] ST_SPARE7 = 3'd7;

	// Drain of the window plus the front queue, with margin.
	localparam int DRAIN_CYCLES = 2 * fsg_pkg::MAX_WIDTH + 16;
	// Receiver hold-off that backs the block up into its input.
	localparam int HOLD_CYCLES  = 300;
	// Cycles with no item moving on any channel before giving up.
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 170;

	logic                          clk;
	logic                          arst_n     = 1'b0;
	logic                          cfg_valid  = 1'b0;
	logic                          cfg_ready;
	logic [fsg_pkg::CFG_IDX_W-1:0] cfg_index  = fsg_pkg::REG_GRID_WIDTH;
	logic [fsg_pkg::CFG_DAT_W-1:0] cfg_data   = '0;
	logic                          in_valid   = 1'b0;
	logic                          in_ready;
	logic [fsg_pkg::CELL_W-1:0]    cell_state = fsg_pkg::ST_UNTOUCHED;
	logic                          out_valid;
	logic                          out_ready  = 1'b0;
	logic [fsg_pkg::CELL_W-1:0]    next_state;
	logic                          frame_last;

	int                            fail_count;
	int                            pending;
	int                            idle_cycles;
	logic                          hold_req   = 1'b0;
	logic                          hold_on    = 1'b0;

	// 3x3 frame for Moore: the center only has burning cells on its diagonals,
	// and two corners burn, so the clipped corner reads are exercised.
	logic [fsg_pkg::CELL_W-1:0] frame_moore [9] = '{
		fsg_pkg::ST_BURNING,  fsg_pkg::ST_UNTOUCHED, ST_SPARE6,
		fsg_pkg::ST_BURNING2, ST_SPARE5,             fsg_pkg::ST_UNTOUCHED,
		ST_SPARE7,            fsg_pkg::ST_BURNT,     fsg_pkg::ST_BURNING
	};
	// 3x3 frame for star: center sees fire only diagonally, so it must not catch fire.
	logic [fsg_pkg::CELL_W-1:0] frame_star [9] = '{
		fsg_pkg::ST_UNTOUCHED, fsg_pkg::ST_ROCK,      fsg_pkg::ST_BURNING,
		fsg_pkg::ST_UNTOUCHED, ST_SPARE6,             fsg_pkg::ST_UNTOUCHED,
		fsg_pkg::ST_BURNING,   fsg_pkg::ST_UNTOUCHED, ST_SPARE7
	};
	// Smallest grid, 2x2.
	logic [fsg_pkg::CELL_W-1:0] frame_tiny [4] = '{
		fsg_pkg::ST_UNTOUCHED, fsg_pkg::ST_BURNING,
		fsg_pkg::ST_ROCK,      fsg_pkg::ST_UNTOUCHED
	};

	fire_spread_grid_stencil uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_state (cell_state),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_state (next_state),
		.frame_last (frame_last)
	);

	fire_spread_grid_stencil_check stencil_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_state (cell_state),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_state (next_state),
		.frame_last (frame_last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Random cell with a given share of burning cells; the rest spread over
	// all other codes, undefined ones included.
	function automatic logic [fsg_pkg::CELL_W-1:0] random_cell(int burn_pct);
		int r;
		if ($urandom_range(0, 99) < burn_pct)
			return fsg_pkg::ST_BURNING;
		r = $urandom_range(0, 19);
		case (r)
			11, 12:  return fsg_pkg::ST_BURNING2;
			13, 14:  return fsg_pkg::ST_BURNT;
			15, 16:  return fsg_pkg::ST_ROCK;
			17:      return ST_SPARE5;
			18:      return ST_SPARE6;
			19:      return ST_SPARE7;
			default: return fsg_pkg::ST_UNTOUCHED;
		endcase
	endfunction

	// One cell on the in channel. Also drops a cfg valid left up by the last write.
	task automatic send_cell(input logic [fsg_pkg::CELL_W-1:0] value, input bit quiet);
		int gap;
		gap = quiet ? 0 : gap_len();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cell_state <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// Valid stays up on return; the next write reuses it, anything else drops it.
	task automatic cfg_write(input logic [fsg_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [fsg_pkg::CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Wait for every predicted result, then for cells that make no result to
	// work their way through before the block is touched again.
	task automatic settle();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off once the stimulus asks.
	initial begin
		int g;
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				hold_on   <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				g = gap_len();
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				out_ready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					repeat (100) @(posedge clk);
				else
					repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready) ||
		         (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int                            rand_items;
		int                            n;
		int                            cur_w;
		int                            burn_pct;
		int                            r;
		bit                            quiet;
		logic [fsg_pkg::CFG_DAT_W-1:0] w_data;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---------------------------------------------------
		// 3x3 with the mode still at its reset value (Moore)
		cfg_write(fsg_pkg::REG_GRID_WIDTH, 6'd3);
		foreach (frame_moore[i])
			send_cell(frame_moore[i], 1'b0);
		settle();

		// star mode; the upper data bits must be ignored
		cfg_write(fsg_pkg::REG_NBR_MODE, 6'h3F);
		foreach (frame_star[i])
			send_cell(frame_star[i], 1'b0);
		settle();

		// width 0 clamps to 2; two cells make no result, then a width write
		// restarts the frame and those cells are never reported
		cfg_write(fsg_pkg::REG_GRID_WIDTH, 6'd0);
		send_cell(fsg_pkg::ST_BURNING, 1'b0);
		send_cell(fsg_pkg::ST_ROCK, 1'b0);
		settle();
		cfg_write(fsg_pkg::REG_GRID_WIDTH, 6'd1);
		foreach (frame_tiny[i])
			send_cell(frame_tiny[i], 1'b0);
		settle();

		// --- three rows at the largest width ----------------------------
		// width 63 clamps to the maximum; the receiver holds off meanwhile
		// so the queue and window fill and in_ready has to drop
		cfg_write(fsg_pkg::REG_GRID_WIDTH, 6'h3F);
		cfg_write(fsg_pkg::REG_NBR_MODE,
		          {{(fsg_pkg::CFG_DAT_W-1){1'b0}}, fsg_pkg::MODE_MOORE});
		cfg_valid <= 1'b0;
		hold_req  <= 1'b1;
		wait (hold_on);
		@(posedge clk);
		repeat (3 * fsg_pkg::MAX_WIDTH)
			send_cell(random_cell(3), 1'b1);
		cur_w = fsg_pkg::MAX_WIDTH;

		// --- random phases ----------------------------------------------
		// Mostly whole small frames; large widths only as cut-off frames.
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			settle();
			quiet    = ($urandom_range(0, 3) == 0);
			burn_pct = $urandom_range(2, 30);

			if ($urandom_range(0, 99) < 80) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					w_data = fsg_pkg::CFG_DAT_W'($urandom_range(2, 8));
				else if (r < 80)
					w_data = fsg_pkg::CFG_DAT_W'($urandom_range(9, 16));
				else if (r < 88)
					w_data = fsg_pkg::CFG_DAT_W'($urandom_range(0, 1));
				else if (r < 94)
					w_data = fsg_pkg::CFG_DAT_W'($urandom_range(17, 32));
				else
					w_data = fsg_pkg::CFG_DAT_W'($urandom_range(33, 63));
				cfg_write(fsg_pkg::REG_GRID_WIDTH, w_data);
				cur_w = (w_data < 2) ? 2 :
				        (w_data > fsg_pkg::MAX_WIDTH) ? fsg_pkg::MAX_WIDTH : w_data;
			end
			if ($urandom_range(0, 1) == 1)
				cfg_write(fsg_pkg::REG_NBR_MODE, fsg_pkg::CFG_DAT_W'($urandom()));
			// unmapped register indexes must be ignored
			if ($urandom_range(0, 9) == 0)
				cfg_write(fsg_pkg::CFG_IDX_W'($urandom_range(2, 15)),
				          fsg_pkg::CFG_DAT_W'($urandom()));

			if (cur_w <= 8)
				n = cur_w * cur_w * $urandom_range(1, 3);
			else if (cur_w <= 16)
				n = cur_w * cur_w;
			else
				n = $urandom_range(cur_w + 2, 2 * cur_w + 6);
			// now and then a trailing partial frame, cut by the next width write
			if (cur_w <= 16 && $urandom_range(0, 3) == 0)
				n += $urandom_range(1, cur_w * cur_w - 1);

			repeat (n)
				send_cell(random_cell(burn_pct), quiet);
			rand_items += n;
		end

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (pending != 0)
				$display("%0t: %0d results never arrived", $time, pending);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> fire_spread_grid_stencil.f
+incdir+hdl
hdl/fsg_pkg.sv
hdl/fsg_front.sv
hdl/fsg_queue.sv
hdl/fsg_back.sv
hdl/fire_spread_grid_stencil.sv
sim/fire_spread_grid_stencil_check.sv
sim/fire_spread_grid_stencil_tb.sv
